// ----- hw/rtl/aes_pkg.sv -----
package aes_pkg;

  localparam int unsigned BLK_W = 128;
  localparam int unsigned HALF_W = 64;
  localparam int unsigned ROUNDS = 10;

  localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [0:0] CFG_KEY_LOW = 1'b1;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [BLK_W-1:0] blk_t;

  typedef logic [7:0] sbox_arr_t [256];

  localparam sbox_arr_t SBOX = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    logic [7:0] d;
    d = {x[6:0], 1'b0};
    return x[7] ? (d ^ 8'h1B) : d;
  endfunction

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input blk_t b, input int unsigned i);
    return b[BLK_W-1-8*i -: 8];
  endfunction

endpackage

// ----- hw/rtl/aes128_block_encrypt.sv -----
// out_valid rises once an item has passed the input stage, which registers at the start edge, and then
// the ten round cells; the result is accepted at the edge that ends the cycle in which out_valid is high.
// Throughput: one item per cycle; busy stays low, so start may be high every cycle.
// The input stage and the chain of ten registered round cells set the latency; each cell carries its own round key.
// Reset (rst_n low, synchronous) clears the key registers and all valid bits.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
module aes128_block_encrypt
  import aes_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [HALF_W-1:0]    in_plain_high,
  input  logic [HALF_W-1:0]    in_plain_low,
  output logic                 out_valid,
  output logic [HALF_W-1:0]    out_cipher_high,
  output logic [HALF_W-1:0]    out_cipher_low,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data
);

  logic [HALF_W-1:0] key_hi_r;
  logic [HALF_W-1:0] key_lo_r;
  logic              vld0_r;
  blk_t              state0_r;
  blk_t              key0_r;

  logic       vld   [ROUNDS+1];
  blk_t       state [ROUNDS+1];
  blk_t       rkey  [ROUNDS+1];
  logic [7:0] rcon  [ROUNDS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      vld0_r   <= 1'b0;
    end else begin
      vld0_r <= start;
      if (cfg_we && cfg_index == CFG_KEY_HIGH) begin
        key_hi_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_KEY_LOW) begin
        key_lo_r <= cfg_data;
      end
    end
    state0_r <= {in_plain_high, in_plain_low} ^ {key_hi_r, key_lo_r};
    key0_r   <= {key_hi_r, key_lo_r};
  end

  assign vld[0]   = vld0_r;
  assign state[0] = state0_r;
  assign rkey[0]  = key0_r;
  assign rcon[0]  = 8'h01;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    assign rcon[g+1] = xtime(rcon[g]);
    aes_round_cell #(
      .LAST (g == ROUNDS-1)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .vld_in    (vld[g]),
      .state_in  (state[g]),
      .key_in    (rkey[g]),
      .rcon_in   (rcon[g]),
      .vld_out   (vld[g+1]),
      .state_out (state[g+1]),
      .key_out   (rkey[g+1])
    );
  end

  assign busy            = 1'b0;
  assign out_valid       = vld[ROUNDS];
  assign out_cipher_high = state[ROUNDS][BLK_W-1:HALF_W];
  assign out_cipher_low  = state[ROUNDS][HALF_W-1:0];

`ifndef SYNTH
  a_in_to_first: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> vld[0])
    else $error("item lost at entry");
  a_chain: assert property (@(posedge clk) disable iff (!rst_n)
    vld[0] |-> ##10 out_valid)
    else $error("item lost in round chain");
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !vld[0] |-> ##10 !out_valid)
    else $error("result without item");
`endif

endmodule

// ----- hw/rtl/aes_round_cell.sv -----
module aes_round_cell
  import aes_pkg::*;
#(
  parameter bit LAST = 1'b0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       vld_in,
  input  blk_t       state_in,
  input  blk_t       key_in,
  input  logic [7:0] rcon_in,
  output logic       vld_out,
  output blk_t       state_out,
  output blk_t       key_out
);

  logic vld_r;
  blk_t state_r;
  blk_t key_r;
  blk_t key_nxt;
  blk_t ss;
  blk_t mix;
  blk_t state_nxt;

  always_comb begin
    logic [7:0] k [16];
    logic [7:0] t [4];
    for (int i = 0; i < 16; i++) begin
      k[i] = get_byte(key_in, i);
    end
    t[0] = SBOX[k[13]] ^ rcon_in;
    t[1] = SBOX[k[14]];
    t[2] = SBOX[k[15]];
    t[3] = SBOX[k[12]];
    for (int i = 0; i < 4; i++) begin
      k[i] = k[i] ^ t[i];
    end
    for (int i = 4; i < 16; i++) begin
      k[i] = k[i] ^ k[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      key_nxt[BLK_W-1-8*i -: 8] = k[i];
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[BLK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(state_in, 4*((c+r)%4)+r)];
      end
    end
  end

  always_comb begin
    logic [7:0] a [4];
    logic [7:0] d [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = get_byte(ss, 4*c+r);
        d[r] = xtime(a[r]);
      end
      mix[BLK_W-1-8*(4*c)   -: 8] = d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3];
      mix[BLK_W-1-8*(4*c+1) -: 8] = a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3];
      mix[BLK_W-1-8*(4*c+2) -: 8] = a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3];
      mix[BLK_W-1-8*(4*c+3) -: 8] = d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3];
    end
  end

  assign state_nxt = (LAST ? ss : mix) ^ key_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    state_r <= state_nxt;
    key_r   <= key_nxt;
  end

  assign vld_out   = vld_r;
  assign state_out = state_r;
  assign key_out   = key_r;

endmodule

// ----- verif/aes_checker.sv -----
module aes_checker
  import aes_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [HALF_W-1:0] in_plain_high,
  input  logic [HALF_W-1:0] in_plain_low,
  input  logic              out_valid,
  input  logic [HALF_W-1:0] out_cipher_high,
  input  logic [HALF_W-1:0] out_cipher_low,
  input  logic              cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending_blocks
);

  logic [HALF_W-1:0] key_high;
  logic [HALF_W-1:0] key_low;
  blk_t cipher_queue[$];

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return x[7] ? ({x[6:0], 1'b0} ^ 8'h1B) : {x[6:0], 1'b0};
  endfunction

  function automatic blk_t encrypt_block(input blk_t plain, input blk_t key);
    logic [7:0] s [16];
    logic [7:0] k [16];
    logic [7:0] t [16];
    logic [7:0] rc;
    logic [7:0] a0, a1, a2, a3, t0, t1, t2, t3;
    blk_t res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      s[i] = plain[127-8*i -: 8] ^ key[127-8*i -: 8];
      k[i] = key[127-8*i -: 8];
    end
    for (int rnd = 1; rnd <= ROUNDS; rnd++) begin
      t0 = SBOX[k[13]] ^ rc;
      t1 = SBOX[k[14]];
      t2 = SBOX[k[15]];
      t3 = SBOX[k[12]];
      k[0] ^= t0; k[1] ^= t1; k[2] ^= t2; k[3] ^= t3;
      for (int i = 4; i < 16; i++) k[i] ^= k[i-4];
      rc = gf_dbl(rc);
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
      s = t;
      if (rnd != ROUNDS) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
          s[4*c+1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
          s[4*c+2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
          s[4*c+3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= k[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  assign pending_blocks = cipher_queue.size();

  always @(posedge clk) begin
    blk_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      key_high <= '0;
      key_low <= '0;
      fail_count <= 0;
      cipher_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_KEY_HIGH) key_high <= cfg_data;
        else if (cfg_index == CFG_KEY_LOW) key_low <= cfg_data;
      end
      if (start && !busy)
        cipher_queue.push_back(encrypt_block({in_plain_high, in_plain_low},
                                             {key_high, key_low}));
      if (out_valid) begin
        if (cipher_queue.size() == 0) begin
          $display("%0t: unexpected block, actual %h_%h", $time,
                   out_cipher_high, out_cipher_low);
          errs = errs + 1;
        end else begin
          want = cipher_queue.pop_front();
          if (want[127:64] !== out_cipher_high) begin
            $display("%0t: cipher_high expected %h actual %h", $time,
                     want[127:64], out_cipher_high);
            errs = errs + 1;
          end
          if (want[63:0] !== out_cipher_low) begin
            $display("%0t: cipher_low expected %h actual %h", $time,
                     want[63:0], out_cipher_low);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ----- verif/tb.sv -----
module tb;
  import aes_pkg::*;

  localparam int LATENCY = 11;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [HALF_W-1:0] in_plain_high = '0;
  logic [HALF_W-1:0] in_plain_low = '0;
  logic out_valid;
  logic [HALF_W-1:0] out_cipher_high;
  logic [HALF_W-1:0] out_cipher_low;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY_HIGH;
  logic [HALF_W-1:0] cfg_data = '0;
  int fail_count;
  int pending_blocks;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  aes128_block_encrypt DUT (.*);

  aes_checker checker_inst (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [HALF_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_key(input logic [HALF_W-1:0] high_val,
                           input logic [HALF_W-1:0] low_val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_KEY_HIGH;
    cfg_data <= high_val;
    @(posedge clk);
    cfg_index <= CFG_KEY_LOW;
    cfg_data <= low_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_blocks != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // hold start across consecutive items; drop it only in gaps
  task automatic send_block(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
                            input bit keep_start);
    start <= 1'b1;
    in_plain_high <= hi;
    in_plain_low <= lo;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!keep_start) start <= 1'b0;
  endtask

  task automatic random_blocks(input int count, input bit bursty);
    int burst;
    int n;
    n = 0;
    while (n < count) begin
      burst = bursty ? $urandom_range(1, 12) : 40;
      for (int i = 0; i < burst && n < count; i++) begin
        send_block(rand64(), rand64(), (i != burst - 1 || !bursty) && n != count - 1);
        n++;
      end
      if (bursty) repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);
    drain();
    write_key(64'h2B7E151628AED2A6, 64'hABF7158809CF4F3C);
    send_block(64'h3243F6A8885A308D, 64'h313198A2E0370734, 1'b1);
    send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF, 1'b1);
    send_block(64'h8000000000000000, 64'h0000000000000001, 1'b1);
    send_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 1'b0);
    drain();
    write_key(64'h0001020304050607, 64'h08090A0B0C0D0E0F);
    send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF, 1'b1);
    send_block('0, '1, 1'b1);
    send_block('1, '0, 1'b0);
    drain();
    write_key('1, '1);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      write_key(rand64(), rand64());
      random_blocks(100, phase != 2);
      drain();
    end
    write_key('0, '0);
    random_blocks(30, 1'b1);
    drain();
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
